[hdl/rft_pkg.sv]
// ============================================================================
// rft_pkg
// Shared types and constants for the range filter trie query block.
// ============================================================================
package rft_pkg;

    localparam int SHAPE_DEPTH_DEF = 1024;
    localparam int LEAF_DEPTH_DEF  = 1024;

    // request codes
    localparam logic [1:0] REQ_LOAD_SHAPE = 2'd0;
    localparam logic [1:0] REQ_LOAD_LEAF  = 2'd1;
    localparam logic [1:0] REQ_POINT      = 2'd2;
    localparam logic [1:0] REQ_RANGE      = 2'd3;

    // register index (bit 2 of the byte address)
    localparam logic REG_LOWER_BOUND = 1'b0;
    localparam logic REG_DOMAIN      = 1'b1;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_INIT    = 16'h0002,
        ST_MID     = 16'h0004,
        ST_MID2    = 16'h0008,
        ST_CMP     = 16'h0010,
        ST_L_A     = 16'h0020,
        ST_L_B     = 16'h0040,
        ST_R_B     = 16'h0080,
        ST_R_A     = 16'h0100,
        ST_SK_IS   = 16'h0200,
        ST_SK_A    = 16'h0400,
        ST_SK_B    = 16'h0800,
        ST_LEAF_IS = 16'h1000,
        ST_LEAF    = 16'h2000,
        ST_CHECK   = 16'h4000,
        ST_OUT     = 16'h8000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_shape;
        logic load_leaf;
        logic load_query;
        logic init;
        logic mid_a;
        logic mid_b;
        logic rd_shape;
        logic rd_sel_next;   // read pos+1 instead of pos
        logic rd_leaf;
        logic set_fault;
        logic left_leaf;
        logic left_step;
        logic save_rleaf;
        logic right_leaf;
        logic right_step;
        logic skip_start;
        logic save_a;
        logic skip_step;
        logic leaf_take;
        logic next_range;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_range;
        logic go_right;
        logic q_bit;
        logic q_oob;
        logic rleaf;
        logic pend_zero_next;
        logic leaf_oob;
        logic hit;
        logic first;
        logic end_le_prev;
        logic end_lt_khi;
        logic out_free;
    } status_t;

endpackage

[hdl/rft_ctrl.sv]
// ============================================================================
// rft_ctrl
// Sequencer for trie loads, point descents, subtree skips and range repeats.
// ============================================================================
module rft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        req_type,
    output logic              in_stall,
    input  rft_pkg::status_t  sts,
    output rft_pkg::cmd_t     cmd
);

    rft_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rft_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != rft_pkg::ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            rft_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == rft_pkg::REQ_LOAD_SHAPE)
                        cmd.load_shape = 1'b1;
                    else if (req_type == rft_pkg::REQ_LOAD_LEAF)
                        cmd.load_leaf = 1'b1;
                    else
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = rft_pkg::ST_INIT;
                    end
                end
            end
            rft_pkg::ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = rft_pkg::ST_MID;
            end
            rft_pkg::ST_MID:
            begin
                cmd.mid_a  = 1'b1;
                state_next = rft_pkg::ST_MID2;
            end
            rft_pkg::ST_MID2:
            begin
                cmd.mid_b  = 1'b1;
                state_next = rft_pkg::ST_CMP;
            end
            rft_pkg::ST_CMP:
            begin
                // right child looks at the second bit of the pair first
                cmd.rd_shape    = 1'b1;
                cmd.rd_sel_next = sts.go_right;
                state_next      = sts.go_right ? rft_pkg::ST_R_B : rft_pkg::ST_L_A;
            end
            rft_pkg::ST_L_A:
            begin
                if (sts.q_oob)
                begin
                    cmd.set_fault = 1'b1;
                    state_next    = rft_pkg::ST_OUT;
                end
                else if (!sts.q_bit)
                begin
                    cmd.left_leaf = 1'b1;
                    state_next    = rft_pkg::ST_LEAF_IS;
                end
                else
                begin
                    cmd.rd_shape    = 1'b1;
                    cmd.rd_sel_next = 1'b1;
                    state_next      = rft_pkg::ST_L_B;
                end
            end
            rft_pkg::ST_L_B:
            begin
                if (sts.q_oob)
                begin
                    cmd.set_fault = 1'b1;
                    state_next    = rft_pkg::ST_OUT;
                end
                else
                begin
                    cmd.left_step = 1'b1;
                    state_next    = rft_pkg::ST_MID;
                end
            end
            rft_pkg::ST_R_B:
            begin
                if (sts.q_oob)
                begin
                    cmd.set_fault = 1'b1;
                    state_next    = rft_pkg::ST_OUT;
                end
                else
                begin
                    cmd.save_rleaf = 1'b1;
                    cmd.rd_shape   = 1'b1;
                    state_next     = rft_pkg::ST_R_A;
                end
            end
            rft_pkg::ST_R_A:
            begin
                if (sts.q_oob)
                begin
                    cmd.set_fault = 1'b1;
                    state_next    = rft_pkg::ST_OUT;
                end
                else if (sts.rleaf)
                begin
                    cmd.right_leaf = 1'b1;
                    state_next     = rft_pkg::ST_LEAF_IS;
                end
                else if (!sts.q_bit)
                begin
                    cmd.right_step = 1'b1;
                    state_next     = rft_pkg::ST_MID;
                end
                else
                begin
                    cmd.skip_start = 1'b1;
                    state_next     = rft_pkg::ST_SK_IS;
                end
            end
            rft_pkg::ST_SK_IS:
            begin
                cmd.rd_shape = 1'b1;
                state_next   = rft_pkg::ST_SK_A;
            end
            rft_pkg::ST_SK_A:
            begin
                if (sts.q_oob)
                begin
                    cmd.set_fault = 1'b1;
                    state_next    = rft_pkg::ST_OUT;
                end
                else
                begin
                    cmd.save_a      = 1'b1;
                    cmd.rd_shape    = 1'b1;
                    cmd.rd_sel_next = 1'b1;
                    state_next      = rft_pkg::ST_SK_B;
                end
            end
            rft_pkg::ST_SK_B:
            begin
                if (sts.q_oob)
                begin
                    cmd.set_fault = 1'b1;
                    state_next    = rft_pkg::ST_OUT;
                end
                else
                begin
                    cmd.skip_step = 1'b1;
                    state_next    = sts.pend_zero_next ? rft_pkg::ST_MID : rft_pkg::ST_SK_IS;
                end
            end
            rft_pkg::ST_LEAF_IS:
            begin
                cmd.rd_leaf = 1'b1;
                state_next  = rft_pkg::ST_LEAF;
            end
            rft_pkg::ST_LEAF:
            begin
                if (sts.leaf_oob)
                begin
                    cmd.set_fault = 1'b1;
                    state_next    = rft_pkg::ST_OUT;
                end
                else
                begin
                    cmd.leaf_take = 1'b1;
                    state_next    = rft_pkg::ST_CHECK;
                end
            end
            rft_pkg::ST_CHECK:
            begin
                // stop on a hit, a point query, a stuck range or the upper end
                if (sts.hit || !sts.is_range)
                    state_next = rft_pkg::ST_OUT;
                else if (!sts.first && sts.end_le_prev)
                    state_next = rft_pkg::ST_OUT;
                else if (sts.end_lt_khi)
                begin
                    cmd.next_range = 1'b1;
                    state_next     = rft_pkg::ST_INIT;
                end
                else
                    state_next = rft_pkg::ST_OUT;
            end
            rft_pkg::ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rft_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rft_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/rft_datapath.sv]
// ============================================================================
// rft_datapath
// Trie bit stores, descent registers, leaf counter and the output word.
// ============================================================================
module rft_datapath #(
    parameter int SHAPE_DEPTH = rft_pkg::SHAPE_DEPTH_DEF,
    parameter int LEAF_DEPTH  = rft_pkg::LEAF_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rft_pkg::cmd_t     cmd,
    output rft_pkg::status_t  sts,
    input  logic [1:0]        req_type,
    input  logic [9:0]        bit_index,
    input  logic              bit_value,
    input  logic [31:0]       key_low,
    input  logic [31:0]       key_high,
    input  logic [31:0]       lower_bound,
    input  logic [31:0]       domain,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic              walk_error
);

    localparam int SAW = (SHAPE_DEPTH > 1) ? $clog2(SHAPE_DEPTH) : 1;
    localparam int LAW = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1;
    localparam int CW  = ((SAW > LAW) ? SAW : LAW) + 2;

    logic shape_mem [SHAPE_DEPTH];
    logic leaf_mem  [LEAF_DEPTH];

    logic [31:0] idx_ext;
    logic [CW-1:0] rd_pos;
    logic [CW-1:0] pend_next;

    logic [CW-1:0] pos_reg, leaf_reg, pend_reg;
    logic [32:0]   lo_reg, hi_reg, mid_reg, half_reg, key_reg, end_reg, prev_reg;
    logic [31:0]   khi_reg;
    logic          ge_reg, range_reg, first_reg, fault_reg, hit_reg;
    logic          q_bit_reg, q_oob_reg, l_bit_reg, l_oob_reg, rleaf_reg, a_leaf_reg;
    logic          out_valid_reg, out_hit_reg, out_err_reg;

    assign idx_ext = 32'(bit_index);
    assign rd_pos  = cmd.rd_sel_next ? pos_reg + CW'(1) : pos_reg;

    // pending subtrees: one taken, one more for each inner child
    assign pend_next = pend_reg + CW'(1) - CW'(a_leaf_reg) - CW'(!q_bit_reg);

    // store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_shape && idx_ext < 32'(SHAPE_DEPTH))
            shape_mem[idx_ext[SAW-1:0]] <= bit_value;
        if (cmd.load_leaf && idx_ext < 32'(LEAF_DEPTH))
            leaf_mem[idx_ext[LAW-1:0]] <= bit_value;
        if (cmd.rd_shape)
        begin
            q_bit_reg <= shape_mem[rd_pos[SAW-1:0]];
            q_oob_reg <= (rd_pos >= CW'(SHAPE_DEPTH));
        end
        if (cmd.rd_leaf)
        begin
            l_bit_reg <= leaf_mem[leaf_reg[LAW-1:0]];
            l_oob_reg <= (leaf_reg >= CW'(LEAF_DEPTH));
        end
    end

    // descent payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            key_reg <= {1'b0, key_low};
            khi_reg <= key_high;
        end
        if (cmd.next_range)
        begin
            prev_reg <= end_reg;
            key_reg  <= end_reg + 33'd1;
        end
        if (cmd.init)
        begin
            lo_reg   <= {1'b0, lower_bound};
            hi_reg   <= {1'b0, lower_bound} + {1'b0, domain};
            pos_reg  <= '0;
            leaf_reg <= '0;
        end
        if (cmd.mid_a)
        begin
            ge_reg   <= (hi_reg >= lo_reg);
            half_reg <= (hi_reg - lo_reg) >> 1;
        end
        if (cmd.mid_b)
            mid_reg <= ge_reg ? lo_reg + half_reg : lo_reg;
        if (cmd.left_leaf)
            end_reg <= mid_reg;
        if (cmd.left_step)
        begin
            leaf_reg <= leaf_reg + CW'(!q_bit_reg);
            pos_reg  <= pos_reg + CW'(2);
            hi_reg   <= mid_reg;
        end
        if (cmd.save_rleaf)
            rleaf_reg <= !q_bit_reg;
        if (cmd.right_leaf)
        begin
            leaf_reg <= leaf_reg + CW'(!q_bit_reg);
            end_reg  <= hi_reg;
        end
        if (cmd.right_step)
        begin
            pos_reg  <= pos_reg + CW'(2);
            leaf_reg <= leaf_reg + CW'(1);
            lo_reg   <= mid_reg + 33'd1;
        end
        if (cmd.skip_start)
        begin
            pos_reg  <= pos_reg + CW'(2);
            pend_reg <= CW'(1);
            lo_reg   <= mid_reg + 33'd1;
        end
        if (cmd.save_a)
            a_leaf_reg <= !q_bit_reg;
        if (cmd.skip_step)
        begin
            pend_reg <= pend_next;
            leaf_reg <= leaf_reg + CW'(a_leaf_reg) + CW'(!q_bit_reg);
            pos_reg  <= pos_reg + CW'(2);
        end
    end

    // query control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= 1'b0;
            first_reg <= 1'b0;
            fault_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_query)
            begin
                range_reg <= (req_type == rft_pkg::REQ_RANGE);
                first_reg <= 1'b1;
                fault_reg <= 1'b0;
                hit_reg   <= 1'b0;
            end
            if (cmd.next_range)
                first_reg <= 1'b0;
            if (cmd.set_fault)
                fault_reg <= 1'b1;
            if (cmd.leaf_take)
                hit_reg <= l_bit_reg;
        end
    end

    // output word; hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_hit_reg <= hit_reg & ~fault_reg;
            out_err_reg <= fault_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign walk_error = out_err_reg;

    // status
    always_comb
    begin
        sts.is_range       = range_reg;
        sts.go_right       = (key_reg > mid_reg);
        sts.q_bit          = q_bit_reg;
        sts.q_oob          = q_oob_reg;
        sts.rleaf          = rleaf_reg;
        sts.pend_zero_next = (pend_next == '0);
        sts.leaf_oob       = l_oob_reg;
        sts.hit            = hit_reg;
        sts.first          = first_reg;
        sts.end_le_prev    = (end_reg <= prev_reg);
        sts.end_lt_khi     = (end_reg < {1'b0, khi_reg});
        sts.out_free       = !out_valid_reg || !out_stall;
    end

endmodule

[hdl/range_filter_trie_query.sv]
// ============================================================================
// range_filter_trie_query
// Point and range membership lookups against a trie held as shape and leaf
// bit stores, with an APB-style port for the domain registers.
// ============================================================================
//  channel   signals                                        direction
//  input     in_valid/in_stall, req_type, bit_index,       into block
//            bit_value, key_low, key_high
//  output    out_valid/out_stall, hit, walk_error          out of block
//  config    psel, penable, pwrite, paddr, pwdata, prdata  APB slave
//
//  A load is written from idle and gives no word. A query sets up each
//  descent in INIT, walks each trie level through MID, MID2, CMP and the
//  shape reads, passes a skipped subtree pair by pair, then reads the leaf
//  and checks the range; a range query repeats the descent per leaf
//  interval, and OUT hands off the word. The shape store has one read port.
//  One item is worked at a time; the result sits in an output register, so
//  a stall on the output holds only that word. No clearing pass after reset.
// ============================================================================
module range_filter_trie_query #(
    parameter int SHAPE_DEPTH = rft_pkg::SHAPE_DEPTH_DEF,
    parameter int LEAF_DEPTH  = rft_pkg::LEAF_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [9:0]  bit_index,
    input  logic        bit_value,
    input  logic [31:0] key_low,
    input  logic [31:0] key_high,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        walk_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rft_pkg::cmd_t    cmd;
    rft_pkg::status_t sts;

    logic [31:0] lower_bound_reg, domain_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= '0;
            domain_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == rft_pkg::REG_LOWER_BOUND)
                lower_bound_reg <= pwdata;
            else
                domain_reg <= pwdata;
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            rft_pkg::REG_LOWER_BOUND: prdata = lower_bound_reg;
            rft_pkg::REG_DOMAIN:      prdata = domain_reg;
            default:                  prdata = '0;
        endcase
    end

    rft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rft_datapath #(
        .SHAPE_DEPTH (SHAPE_DEPTH),
        .LEAF_DEPTH  (LEAF_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .bit_index   (bit_index),
        .bit_value   (bit_value),
        .key_low     (key_low),
        .key_high    (key_high),
        .lower_bound (lower_bound_reg),
        .domain      (domain_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .walk_error  (walk_error)
    );

endmodule
